// ===== rtl/fla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_pkg
// Shared types and constants for the free list block allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int MAX_BLOCKS   = 255;
  localparam int IDX_W        = 8;
  localparam int BYTES_W      = 13;
  localparam int OFFSET_W     = 20;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;
  localparam int MAX_BYTES    = 4096;

  localparam logic [IDX_W-1:0]   NUM_BLOCKS_RST  = IDX_W'(MAX_BLOCKS);
  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = BYTES_W'(16);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = CFG_IDX_W'(1);

  // request codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_EMPTY    = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_RANGE    = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_FULL     = STATUS_W'(3);

  typedef enum logic {
    S_IDLE,
    S_READ
  } fla_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]   num_blocks;
    logic [BYTES_W-1:0] block_bytes;
  } fla_cfg_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } fla_link_req_t;

endpackage

// ===== rtl/fla_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_cfg_regs
// Configuration registers with range clamping and list rebuild pulse.
// ----------------------------------------------------------------------------
module fla_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [fla_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [fla_pkg::CFG_DATA_W-1:0]  wr_data,
  output fla_pkg::fla_cfg_t               cfg,
  output logic                            rebuild
);
  import fla_pkg::*;

  logic [IDX_W-1:0]   num_blocks_r;
  logic [IDX_W-1:0]   num_blocks_nxt;
  logic [BYTES_W-1:0] block_bytes_r;
  logic [BYTES_W-1:0] block_bytes_nxt;
  logic [IDX_W-1:0]   nb_clamp;
  logic [BYTES_W-1:0] bb_clamp;

  always_comb begin
    nb_clamp = wr_data[IDX_W-1:0];
    if (nb_clamp == '0) begin
      nb_clamp = IDX_W'(1);
    end else if (nb_clamp > IDX_W'(MAX_BLOCKS)) begin
      nb_clamp = IDX_W'(MAX_BLOCKS);
    end
    bb_clamp = wr_data[BYTES_W-1:0];
    if (bb_clamp == '0) begin
      bb_clamp = BYTES_W'(1);
    end else if (bb_clamp > BYTES_W'(MAX_BYTES)) begin
      bb_clamp = BYTES_W'(MAX_BYTES);
    end
  end

  always_comb begin
    num_blocks_nxt  = num_blocks_r;
    block_bytes_nxt = block_bytes_r;
    rebuild         = 1'b0;
    if (wr_en) begin
      case (wr_index)
        CFG_NUM_BLOCKS: begin
          num_blocks_nxt = nb_clamp;
          rebuild        = 1'b1;
        end
        CFG_BLOCK_BYTES: begin
          block_bytes_nxt = bb_clamp;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_blocks_r  <= NUM_BLOCKS_RST;
      block_bytes_r <= BLOCK_BYTES_RST;
    end else begin
      num_blocks_r  <= num_blocks_nxt;
      block_bytes_r <= block_bytes_nxt;
    end
  end

  assign cfg.num_blocks  = num_blocks_r;
  assign cfg.block_bytes = block_bytes_r;

endmodule

// ===== rtl/fla_link_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_link_mem
// Link store of the free list: one write and one registered read per cycle.
// Entries not written since the last rebuild read as their index plus one.
// ----------------------------------------------------------------------------
module fla_link_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rebuild,
  input  fla_pkg::fla_link_req_t       req,
  output logic [fla_pkg::IDX_W-1:0]    rd_link
);
  import fla_pkg::*;

  logic [IDX_W-1:0]      mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] written_r;
  logic [IDX_W-1:0]      rd_data_r;
  logic [IDX_W-1:0]      rd_addr_r;
  logic                  rd_written_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
      rd_addr_r <= req.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || rebuild) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_written_r <= written_r[req.rd_addr];
      end
    end
  end

  // untouched entries keep their initial chain value
  assign rd_link = rd_written_r ? rd_data_r : IDX_W'(rd_addr_r + 1'b1);

endmodule

// ===== rtl/free_list_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_block_allocator
// Hands out and takes back equal blocks of one chunk via an intrusive list.
// ----------------------------------------------------------------------------
// Input channel in_*: in_func selects allocate or free, in_free_index names
// the block to free. Each transaction gives exactly one result transaction
// on out_*: status, block index, byte offset and the free count afterwards.
// A free, or any request rejected with an error status, is answered in the
// cycle after acceptance. A successful allocate reads the link at the list
// head from the link memory, waits in S_READ for the registered read data
// and is answered from it; no new request is taken while in S_READ. A new
// request is taken while the previous result is still held, provided that
// result is not stalled. When out_stall is high on a valid result, the
// result register holds and in_stall rises.
// Configuration writes (cfg_*) are taken while no request is in flight and
// hold off new requests while cfg_valid is high; writing the block count
// rebuilds the free list at once. After reset the chunk has 255 free blocks
// of 16 bytes, head at block 0.
// ----------------------------------------------------------------------------
module free_list_block_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic [fla_pkg::IDX_W-1:0]       in_free_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fla_pkg::STATUS_W-1:0]    out_status,
  output logic [fla_pkg::IDX_W-1:0]       out_block_index,
  output logic [fla_pkg::OFFSET_W-1:0]    out_byte_offset,
  output logic [fla_pkg::IDX_W-1:0]       out_free_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fla_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fla_pkg::*;

  fla_cfg_t      cfg;
  logic          rebuild;
  fla_link_req_t link_req;
  logic [IDX_W-1:0] rd_link;

  fla_state_t state_r;
  fla_state_t state_nxt;

  logic [IDX_W-1:0]    head_r;
  logic [IDX_W-1:0]    head_nxt;
  logic [IDX_W-1:0]    total_r;
  logic [IDX_W-1:0]    total_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [STATUS_W-1:0] out_status_nxt;
  logic [IDX_W-1:0]    out_index_r;
  logic [IDX_W-1:0]    out_index_nxt;
  logic [OFFSET_W-1:0] out_offset_r;
  logic [OFFSET_W-1:0] out_offset_nxt;
  logic [IDX_W-1:0]    out_count_r;
  logic [IDX_W-1:0]    out_count_nxt;

  logic                      out_busy;
  logic                      in_accept;
  logic                      alloc_ok;
  logic [IDX_W-1:0]          mul_idx;
  logic [IDX_W+BYTES_W-1:0]  product;

  // clamped block count of a write, matches the configuration register
  function automatic logic [IDX_W-1:0] u_cfg_num(input logic [CFG_DATA_W-1:0] d);
    logic [IDX_W-1:0] v;
    v = d[IDX_W-1:0];
    if (v == '0) begin
      v = IDX_W'(1);
    end else if (v > IDX_W'(MAX_BLOCKS)) begin
      v = IDX_W'(MAX_BLOCKS);
    end
    return v;
  endfunction

  fla_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg),
    .rebuild  (rebuild)
  );

  fla_link_mem u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .rebuild (rebuild),
    .req     (link_req),
    .rd_link (rd_link)
  );

  assign out_busy  = out_valid_r && out_stall;
  // a pending register write goes ahead of a new request
  assign in_stall  = (state_r != S_IDLE) || out_busy || cfg_valid;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);

  assign alloc_ok = (total_r != '0) && (head_r < cfg.num_blocks);

  // one shared multiplier for the byte offset
  assign mul_idx = (state_r == S_READ) ? head_r : in_free_index;
  assign product = mul_idx * cfg.block_bytes;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept && in_func == FUNC_ALLOC && alloc_ok) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (!out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    head_nxt       = head_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_offset_nxt = out_offset_r;
    out_count_nxt  = out_count_r;
    link_req       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          out_valid_nxt  = 1'b1;
          out_offset_nxt = '0;
          out_count_nxt  = total_r;
          if (in_func == FUNC_ALLOC) begin
            out_status_nxt = ST_EMPTY;
            out_index_nxt  = '0;
            if (alloc_ok) begin
              // result comes after the link read
              out_valid_nxt    = 1'b0;
              link_req.rd_en   = 1'b1;
              link_req.rd_addr = head_r;
            end
          end else begin
            out_index_nxt = in_free_index;
            if (in_free_index >= cfg.num_blocks) begin
              out_status_nxt = ST_RANGE;
            end else if (total_r >= cfg.num_blocks) begin
              out_status_nxt = ST_FULL;
            end else begin
              link_req.wr_en   = 1'b1;
              link_req.wr_addr = in_free_index;
              link_req.wr_data = head_r;
              head_nxt         = in_free_index;
              total_nxt        = IDX_W'(total_r + 1'b1);
              out_status_nxt   = ST_OK;
              out_offset_nxt   = product[OFFSET_W-1:0];
              out_count_nxt    = IDX_W'(total_r + 1'b1);
            end
          end
        end
      end
      S_READ: begin
        if (!out_busy) begin
          head_nxt       = rd_link;
          total_nxt      = IDX_W'(total_r - 1'b1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_index_nxt  = head_r;
          out_offset_nxt = product[OFFSET_W-1:0];
          out_count_nxt  = IDX_W'(total_r - 1'b1);
        end
      end
      default: begin
      end
    endcase
    if (rebuild) begin
      head_nxt  = '0;
      total_nxt = u_cfg_num(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      total_r     <= NUM_BLOCKS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_offset_r <= out_offset_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_index = out_index_r;
  assign out_byte_offset = out_offset_r;
  assign out_free_count  = out_count_r;

endmodule

// ===== dv/free_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_checker
// Watches the request, result and register channels of the free list block
// allocator. Keeps its own copy of the link store, head, free count and
// registers, works out the answer to each accepted request and compares
// every accepted result, field by field, with the oldest answer waiting.
// ----------------------------------------------------------------------------
module free_list_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_func,
  input  logic [fla_pkg::IDX_W-1:0]      in_free_index,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [fla_pkg::STATUS_W-1:0]   out_status,
  input  logic [fla_pkg::IDX_W-1:0]      out_block_index,
  input  logic [fla_pkg::OFFSET_W-1:0]   out_byte_offset,
  input  logic [fla_pkg::IDX_W-1:0]      out_free_count,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fla_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             outstanding
);
  import fla_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    block_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic [IDX_W-1:0]    free_count;
  } alloc_answer_t;

  logic [IDX_W-1:0]   link_mem [MAX_BLOCKS];
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   free_blocks;
  logic [IDX_W-1:0]   chunk_blocks;
  logic [BYTES_W-1:0] blk_bytes;
  alloc_answer_t      pending_answers [$];

  function automatic void rebuild_chain();
    for (int i = 0; i < MAX_BLOCKS; i++) link_mem[i] = IDX_W'(i + 1);
    head = '0;
    free_blocks = chunk_blocks;
  endfunction

  function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    int v;
    if (idx == CFG_NUM_BLOCKS) begin
      v = int'(data[IDX_W-1:0]);
      if (v == 0) v = 1;
      if (v > MAX_BLOCKS) v = MAX_BLOCKS;
      chunk_blocks = IDX_W'(v);
      rebuild_chain();
    end else begin
      v = int'(data[BYTES_W-1:0]);
      if (v == 0) v = 1;
      if (v > MAX_BYTES) v = MAX_BYTES;
      blk_bytes = BYTES_W'(v);
    end
  endfunction

  function automatic alloc_answer_t step_free_list(input logic func,
                                                   input logic [IDX_W-1:0] idx);
    alloc_answer_t a;
    a = '0;
    if (func == FUNC_ALLOC) begin
      // a head past the chunk means a list broken by double frees
      if (free_blocks == 0 || head >= chunk_blocks) begin
        a.status = ST_EMPTY;
      end else begin
        a.status = ST_OK;
        a.block_index = head;
        a.byte_offset = OFFSET_W'(int'(head) * int'(blk_bytes));
        head = link_mem[head];
        free_blocks = free_blocks - 1'b1;
      end
    end else begin
      a.block_index = idx;
      if (idx >= chunk_blocks) begin
        a.status = ST_RANGE;
      end else if (free_blocks >= chunk_blocks) begin
        a.status = ST_FULL;
      end else begin
        a.status = ST_OK;
        a.byte_offset = OFFSET_W'(int'(idx) * int'(blk_bytes));
        link_mem[idx] = head;
        head = idx;
        free_blocks = free_blocks + 1'b1;
      end
    end
    a.free_count = free_blocks;
    return a;
  endfunction

  always @(posedge clk) begin
    alloc_answer_t want;
    if (!rst_n) begin
      chunk_blocks = NUM_BLOCKS_RST;
      blk_bytes = BLOCK_BYTES_RST;
      rebuild_chain();
      pending_answers.delete();
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          if (mismatches < 10)
            $display("%t: result transaction with no request waiting", $realtime);
          mismatches++;
        end else begin
          want = pending_answers.pop_front();
          if (out_status !== want.status || out_block_index !== want.block_index ||
              out_byte_offset !== want.byte_offset || out_free_count !== want.free_count) begin
            if (mismatches < 10) begin
              $display("%t: result mismatch: expected st %0d idx %0d off %0d cnt %0d",
                       $realtime, want.status, want.block_index, want.byte_offset,
                       want.free_count);
              $display("%t: got st %0d idx %0d off %0d cnt %0d",
                       $realtime, out_status, out_block_index, out_byte_offset,
                       out_free_count);
            end
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_wdata);
      if (in_valid && !in_stall)
        pending_answers.insert(pending_answers.size(), step_free_list(in_func, in_free_index));
    end
    outstanding = pending_answers.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the free list block allocator: a directed run over the field
// extremes and every status, then phases of random requests under several
// chunk settings and idling mixes, frees mostly of blocks handed out earlier.
// ----------------------------------------------------------------------------
module tb;
  import fla_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_func = FUNC_ALLOC;
  logic [IDX_W-1:0]      in_free_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [IDX_W-1:0]      out_block_index;
  logic [OFFSET_W-1:0]   out_byte_offset;
  logic [IDX_W-1:0]      out_free_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_NUM_BLOCKS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    mismatches;
  int                    outstanding;

  int                    gap_pct = 21;
  int                    stall_pct = 82;
  logic                  sent_funcs [$];
  logic [IDX_W-1:0]      live_blocks [$];

  always #4 clk = ~clk;

  free_list_block_allocator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_free_index   (in_free_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_block_index (out_block_index),
    .out_byte_offset (out_byte_offset),
    .out_free_count  (out_free_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  free_list_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_free_index   (in_free_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_block_index (out_block_index),
    .out_byte_offset (out_byte_offset),
    .out_free_count  (out_free_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // collect blocks handed out so later frees can return them
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && sent_funcs.size() > 0) begin
      if (sent_funcs.pop_front() == FUNC_ALLOC && out_status == ST_OK)
        live_blocks.insert(live_blocks.size(), out_block_index);
    end
  end

  task automatic issue_request(input logic func, input logic [IDX_W-1:0] idx);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_free_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_funcs.insert(sent_funcs.size(), func);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_NUM_BLOCKS) live_blocks.delete();
    @(posedge clk);
  endtask

  task automatic random_items(input int count);
    logic             f;
    logic [IDX_W-1:0] idx;
    int               pick;
    repeat (count) begin
      if ($urandom_range(99) < 25) begin
        // noise: any code, any index, double frees included
        f = 1'($urandom_range(1));
        idx = IDX_W'($urandom_range(255));
      end else if (live_blocks.size() > 0 && $urandom_range(99) < 45) begin
        pick = $urandom_range(live_blocks.size() - 1);
        f = FUNC_FREE;
        idx = live_blocks[pick];
        live_blocks.delete(pick);
      end else begin
        f = FUNC_ALLOC;
        idx = IDX_W'($urandom_range(255));
      end
      issue_request(f, idx);
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] blocks_word,
                           input logic [CFG_DATA_W-1:0] bytes_word,
                           input int gap, input int stall);
    write_reg(CFG_NUM_BLOCKS, blocks_word);
    write_reg(CFG_BLOCK_BYTES, bytes_word);
    gap_pct = gap;
    stall_pct = stall;
    random_items(125);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset chunk: 255 blocks of 16 bytes, all free
    issue_request(FUNC_FREE, 8'd5);
    issue_request(FUNC_FREE, 8'd255);
    issue_request(FUNC_ALLOC, 8'hFF);
    issue_request(FUNC_ALLOC, 8'h00);
    issue_request(FUNC_FREE, 8'd0);
    issue_request(FUNC_ALLOC, 8'h00);
    issue_request(FUNC_FREE, 8'd1);
    issue_request(FUNC_FREE, 8'd0);
    drain();

    // zero count taken as one block, oversize block taken as 4096
    write_reg(CFG_NUM_BLOCKS, 13'd0);
    write_reg(CFG_BLOCK_BYTES, 13'h1FFF);
    issue_request(FUNC_ALLOC, 8'h00);
    issue_request(FUNC_ALLOC, 8'h00);
    issue_request(FUNC_FREE, 8'd1);
    issue_request(FUNC_FREE, 8'd0);
    issue_request(FUNC_FREE, 8'd0);
    drain();

    // two blocks of one byte, run empty, then a double free loops the list
    write_reg(CFG_NUM_BLOCKS, 13'd2);
    write_reg(CFG_BLOCK_BYTES, 13'd0);
    issue_request(FUNC_ALLOC, 8'h00);
    issue_request(FUNC_ALLOC, 8'h00);
    issue_request(FUNC_ALLOC, 8'h00);
    issue_request(FUNC_FREE, 8'd1);
    issue_request(FUNC_FREE, 8'd1);
    issue_request(FUNC_ALLOC, 8'h00);
    issue_request(FUNC_ALLOC, 8'h00);
    issue_request(FUNC_ALLOC, 8'h00);
    drain();

    // upper data bits set on the block count write are dropped
    run_phase(13'h1F08, 13'd4097, 21, 82);
    run_phase(13'd255, 13'd1, 21, 82);
    run_phase(13'd1, 13'd4096, 82, 21);
    run_phase(13'd3, 13'd100, 82, 21);
    run_phase(13'h0E40, 13'h0AAA, 0, 0);
    run_phase(13'h1EFF, 13'h1555, 0, 0);

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
